FILE: rtl/assert_macros.svh
// Assertion macros shared by the span merge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sscm_pkg.sv
// Types, constants and codes shared by the span scale, clip and merge block.
package sscm_pkg;

   localparam int TYPE_COUNT_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int TIME_W       = 48;
   localparam int SCALE_W      = 32;
   localparam int SCALE_FRAC   = 24;
   localparam int PIX_W        = 24;
   localparam int TYPE_FIELD_W = 4;
   localparam int CSR_W        = 48;
   localparam int PART_W       = TIME_W / 2;
   localparam int PROD_W       = PART_W + SCALE_W;
   localparam int ACC_W        = TIME_W + SCALE_W;

   localparam logic [TIME_W-1:0]  VIEW_START_RST  = '0;
   localparam logic [SCALE_W-1:0] PIXEL_SCALE_RST = 32'd16777216;
   localparam logic [PIX_W-1:0]   VIEW_WIDTH_RST  = 24'd491520;
   localparam logic [PIX_W-1:0]   MERGE_GAP_RST   = 24'd512;

   typedef enum logic {
      OP_SEGMENT = 1'b0,
      OP_FLUSH   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_VIEW_START  = 2'd0,
      CSR_PIXEL_SCALE = 2'd1,
      CSR_VIEW_WIDTH  = 2'd2,
      CSR_MERGE_GAP   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACCUM,
      ST_PIXEL,
      ST_DECIDE,
      ST_SEG_EMIT,
      ST_FL_SCAN,
      ST_FL_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic edge_sel;
      logic diff;
      logic mul_lo;
      logic mul_hi;
      logic accum;
      logic store_pix;
      logic scan_mode;
      logic scan_clear;
      logic scan_next;
      logic wr_new;
      logic wr_merge;
      logic set_open;
      logic load_seg;
      logic load_flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic keep;
      logic entry_open;
      logic merge;
      logic scan_open;
      logic cnt_zero;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/span_scale_clip_merge.sv
// Top level of the span scale, clip and merge block.
//
//   Channel   Direction   Handshake             Contents
//   req       in          req_valid/req_stall   operation, seg_type, start_ms, end_ms
//   rsp       out         rsp_valid/rsp_stall   span_type, x_left, x_right, last
//   csr       in          csr_we                csr_index, csr_wdata
//
// A segment converts its start edge, then its end edge; each edge takes a subtract, two 24x32
// partial products on the one shared multiplier, a sum and a clamp. A segment that closes
// an open span also emits it; an ignored segment is not converted. Until a segment or flush
// is done, req_stall holds the next request. A flush emits one result per open type in order.
// Reset is synchronous; it loads the register defaults and closes every span at once.
// A result waits in an output register; a new result waits while rsp_stall holds that register.
module span_scale_clip_merge #(
   parameter int TYPE_COUNT    = sscm_pkg::TYPE_COUNT_DEF,
   parameter int FRACTION_BITS = sscm_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [sscm_pkg::TYPE_FIELD_W-1:0] req_seg_type,
   input  logic [sscm_pkg::TIME_W-1:0]       req_start_ms,
   input  logic [sscm_pkg::TIME_W-1:0]       req_end_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sscm_pkg::TYPE_FIELD_W-1:0] rsp_span_type,
   output logic [sscm_pkg::PIX_W-1:0]        rsp_x_left,
   output logic [sscm_pkg::PIX_W-1:0]        rsp_x_right,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  sscm_pkg::csr_index_type           csr_index,
   input  logic [sscm_pkg::CSR_W-1:0]        csr_wdata
);

   import sscm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   sscm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_operation),
      .req_stall(req_stall),
      .st(st),
      .cmd(cmd)
   );

   sscm_datapath #(
      .TYPE_COUNT(TYPE_COUNT),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .st(st),
      .req_seg_type(req_seg_type),
      .req_start_ms(req_start_ms),
      .req_end_ms(req_end_ms),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_span_type(rsp_span_type),
      .rsp_x_left(rsp_x_left),
      .rsp_x_right(rsp_x_right),
      .rsp_last(rsp_last)
   );

endmodule

FILE: rtl/sscm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sscm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sscm_datapath.sv
// Datapath: configuration registers, edge conversion, span store and result register.
module sscm_datapath #(
   parameter int TYPE_COUNT    = sscm_pkg::TYPE_COUNT_DEF,
   parameter int FRACTION_BITS = sscm_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sscm_pkg::ctrl_cmd_type               cmd,
   output sscm_pkg::dp_status_type              st,
   input  logic [sscm_pkg::TYPE_FIELD_W-1:0]    req_seg_type,
   input  logic [sscm_pkg::TIME_W-1:0]          req_start_ms,
   input  logic [sscm_pkg::TIME_W-1:0]          req_end_ms,
   input  logic                                 csr_we,
   input  sscm_pkg::csr_index_type              csr_index,
   input  logic [sscm_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [sscm_pkg::TYPE_FIELD_W-1:0]    rsp_span_type,
   output logic [sscm_pkg::PIX_W-1:0]           rsp_x_left,
   output logic [sscm_pkg::PIX_W-1:0]           rsp_x_right,
   output logic                                 rsp_last
);

   import sscm_pkg::*;

   localparam int TYPE_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam int CNT_W  = $clog2(TYPE_COUNT + 1);
   localparam int SHIFT  = SCALE_FRAC - FRACTION_BITS;
   localparam logic signed [PIX_W:0] HALF_PIX = (PIX_W + 1)'(1 << (FRACTION_BITS - 1));

   logic [TIME_W-1:0]   view_start_ff, view_start_in;
   logic [SCALE_W-1:0]  pixel_scale_ff, pixel_scale_in;
   logic [PIX_W-1:0]    view_width_ff, view_width_in;
   logic [PIX_W-1:0]    merge_gap_ff, merge_gap_in;

   logic [TYPE_FIELD_W-1:0] type_ff, type_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [TIME_W-1:0]   end_ff, end_in;
   logic [TIME_W-1:0]   ud_ff, ud_in;
   logic                nonpos_ff, nonpos_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [PIX_W-1:0]    x1_ff, x1_in;
   logic [PIX_W-1:0]    x2_ff, x2_in;

   logic [TYPE_COUNT-1:0] open_ff, open_in;
   logic [CNT_W-1:0]    open_cnt_ff, open_cnt_in;
   logic [TYPE_W-1:0]   scan_idx_ff, scan_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TYPE_FIELD_W-1:0] rsp_type_ff, rsp_type_in;
   logic [PIX_W-1:0]    rsp_left_ff, rsp_left_in;
   logic [PIX_W-1:0]    rsp_right_ff, rsp_right_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [TIME_W-1:0]   sel_time;
   logic signed [TIME_W:0] diff;
   logic [PART_W-1:0]   mul_a;
   logic [ACC_W-1:0]    shifted;
   logic [PIX_W-1:0]    pix;
   logic [TYPE_W-1:0]   type_idx;
   logic [TYPE_W-1:0]   ram_addr;
   logic                ram_we;
   logic [2*PIX_W-1:0]  ram_wdata;
   logic [2*PIX_W-1:0]  ram_rdata;
   logic [PIX_W-1:0]    rd_left;
   logic [PIX_W-1:0]    rd_right;
   logic [PIX_W-1:0]    right_max;
   logic signed [PIX_W:0] width_diff;
   logic signed [PIX_W:0] gap_diff;

   // Configuration writes.
   always_comb begin
      view_start_in  = view_start_ff;
      pixel_scale_in = pixel_scale_ff;
      view_width_in  = view_width_ff;
      merge_gap_in   = merge_gap_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VIEW_START:  view_start_in  = csr_wdata[TIME_W-1:0];
            CSR_PIXEL_SCALE: pixel_scale_in = csr_wdata[SCALE_W-1:0];
            CSR_VIEW_WIDTH:  view_width_in  = csr_wdata[PIX_W-1:0];
            CSR_MERGE_GAP:   merge_gap_in   = csr_wdata[PIX_W-1:0];
         endcase
      end
   end

   // Edge conversion: difference, two partial products, sum, clamp.
   assign sel_time = cmd.edge_sel ? end_ff : start_ff;
   assign diff     = $signed({sel_time[TIME_W-1], sel_time})
                   - $signed({view_start_ff[TIME_W-1], view_start_ff});
   assign mul_a    = cmd.mul_hi ? ud_ff[TIME_W-1:PART_W] : ud_ff[PART_W-1:0];
   assign shifted  = acc_ff >> SHIFT;

   always_comb begin
      if (nonpos_ff) begin
         pix = '0;
      end else if ((|shifted[ACC_W-1:PIX_W]) || (shifted[PIX_W-1:0] > view_width_ff)) begin
         pix = view_width_ff;
      end else begin
         pix = shifted[PIX_W-1:0];
      end
   end

   always_comb begin
      type_in   = type_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      ud_in     = ud_ff;
      nonpos_in = nonpos_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      if (cmd.capture) begin
         type_in  = req_seg_type;
         start_in = req_start_ms;
         end_in   = req_end_ms;
      end
      if (cmd.diff) begin
         ud_in     = diff[TIME_W-1:0];
         nonpos_in = diff[TIME_W] || (diff == '0);
      end
      if (cmd.mul_lo || cmd.mul_hi) begin
         prod_in = mul_a * pixel_scale_ff;
      end
      if (cmd.mul_hi) begin
         acc_in = {{(ACC_W - PROD_W){1'b0}}, prod_ff};
      end
      if (cmd.accum) begin
         acc_in = acc_ff + {prod_ff, {PART_W{1'b0}}};
      end
      if (cmd.store_pix) begin
         if (cmd.edge_sel) begin
            x2_in = pix;
         end else begin
            x1_in = pix;
         end
      end
   end

   // Span store.
   assign type_idx  = TYPE_W'(type_ff);
   assign ram_addr  = cmd.scan_mode ? scan_idx_ff : type_idx;
   assign rd_left   = ram_rdata[2*PIX_W-1:PIX_W];
   assign rd_right  = ram_rdata[PIX_W-1:0];
   assign right_max = (x2_ff > rd_right) ? x2_ff : rd_right;
   assign ram_we    = cmd.wr_new || cmd.wr_merge;
   assign ram_wdata = cmd.wr_merge ? {rd_left, right_max} : {x1_ff, x2_ff};

   sscm_ram #(
      .WIDTH(2 * PIX_W),
      .DEPTH(TYPE_COUNT)
   ) u_span_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_addr),
      .wdata(ram_wdata),
      .raddr(ram_addr),
      .rdata(ram_rdata)
   );

   always_comb begin
      open_in     = open_ff;
      open_cnt_in = open_cnt_ff;
      scan_idx_in = scan_idx_ff;
      if (cmd.set_open) begin
         open_in[type_idx] = 1'b1;
         open_cnt_in       = open_cnt_ff + CNT_W'(1);
      end
      if (cmd.load_flush) begin
         open_in[scan_idx_ff] = 1'b0;
         open_cnt_in          = open_cnt_ff - CNT_W'(1);
      end
      if (cmd.scan_clear) begin
         scan_idx_in = '0;
      end else if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + TYPE_W'(1);
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_type_in  = rsp_type_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_seg) begin
         rsp_valid_in = 1'b1;
         rsp_type_in  = type_ff;
         rsp_left_in  = rd_left;
         rsp_right_in = rd_right;
         rsp_last_in  = 1'b1;
      end else if (cmd.load_flush) begin
         rsp_valid_in = 1'b1;
         rsp_type_in  = TYPE_FIELD_W'(scan_idx_ff);
         rsp_left_in  = rd_left;
         rsp_right_in = rd_right;
         rsp_last_in  = (open_cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_start_ff  <= VIEW_START_RST;
         pixel_scale_ff <= PIXEL_SCALE_RST;
         view_width_ff  <= VIEW_WIDTH_RST;
         merge_gap_ff   <= MERGE_GAP_RST;
         open_ff        <= '0;
         open_cnt_ff    <= '0;
         scan_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         view_start_ff  <= view_start_in;
         pixel_scale_ff <= pixel_scale_in;
         view_width_ff  <= view_width_in;
         merge_gap_ff   <= merge_gap_in;
         open_ff        <= open_in;
         open_cnt_ff    <= open_cnt_in;
         scan_idx_ff    <= scan_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      ud_ff        <= ud_in;
      nonpos_ff    <= nonpos_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      x1_ff        <= x1_in;
      x2_ff        <= x2_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Status toward the controller.
   assign width_diff = $signed({1'b0, x2_ff}) - $signed({1'b0, x1_ff});
   assign gap_diff   = $signed({1'b0, x1_ff}) - $signed({1'b0, rd_right});

   assign st.skip       = (32'(req_seg_type) >= 32'(TYPE_COUNT)) || (pixel_scale_ff == '0);
   assign st.keep       = !(width_diff < HALF_PIX);
   assign st.entry_open = open_ff[type_idx];
   assign st.merge      = gap_diff < $signed({1'b0, merge_gap_ff});
   assign st.scan_open  = open_ff[scan_idx_ff];
   assign st.cnt_zero   = (open_cnt_ff == '0);
   assign st.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_span_type = rsp_type_ff;
   assign rsp_x_left    = rsp_left_ff;
   assign rsp_x_right   = rsp_right_ff;
   assign rsp_last      = rsp_last_ff;

`include "assert_macros.svh"

   `ASSERT_IMPLY(a_load_slot_free, cmd.load_seg || cmd.load_flush, !rsp_valid_ff || !rsp_stall, "result loaded over a transaction still held")
   `ASSERT_IMPLY(a_open_count, 1'b1, open_cnt_ff == CNT_W'($countones(open_ff)), "open span count disagrees with open flags")

endmodule

FILE: rtl/sscm_ctrl.sv
// Controller state machine that sequences edge conversion, merging and flushing.
module sscm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_operation,
   output logic                    req_stall,
   input  sscm_pkg::dp_status_type st,
   output sscm_pkg::ctrl_cmd_type  cmd
);

   import sscm_pkg::*;

   state_type state_ff, state_in;
   logic      edge_sel_ff, edge_sel_in;

   always_comb begin
      state_in    = state_ff;
      edge_sel_in = edge_sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            edge_sel_in = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_FLUSH) begin
                  state_in = ST_FL_SCAN;
               end else if (!st.skip) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF:   state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_PIXEL;
         ST_PIXEL: begin
            edge_sel_in = !edge_sel_ff;
            state_in    = edge_sel_ff ? ST_DECIDE : ST_DIFF;
         end
         ST_DECIDE: begin
            if (st.keep && st.entry_open && !st.merge) begin
               state_in = ST_SEG_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEG_EMIT: begin
            if (st.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FL_SCAN: begin
            if (st.cnt_zero) begin
               state_in = ST_IDLE;
            end else if (st.scan_open) begin
               state_in = ST_FL_EMIT;
            end
         end
         ST_FL_EMIT: begin
            if (st.rsp_free) begin
               state_in = ST_FL_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.edge_sel = edge_sel_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.capture    = req_valid;
            cmd.scan_clear = req_valid;
         end
         ST_DIFF:   cmd.diff      = 1'b1;
         ST_MUL_LO: cmd.mul_lo    = 1'b1;
         ST_MUL_HI: cmd.mul_hi    = 1'b1;
         ST_ACCUM:  cmd.accum     = 1'b1;
         ST_PIXEL:  cmd.store_pix = 1'b1;
         ST_DECIDE: begin
            cmd.wr_merge = st.keep && st.entry_open && st.merge;
            cmd.wr_new   = st.keep && !st.entry_open;
            cmd.set_open = st.keep && !st.entry_open;
         end
         ST_SEG_EMIT: begin
            cmd.load_seg = st.rsp_free;
            cmd.wr_new   = st.rsp_free;
         end
         ST_FL_SCAN: begin
            cmd.scan_mode = 1'b1;
            cmd.scan_next = !st.cnt_zero && !st.scan_open;
         end
         ST_FL_EMIT: begin
            cmd.scan_mode  = 1'b1;
            cmd.load_flush = st.rsp_free;
            cmd.scan_next  = st.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         edge_sel_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         edge_sel_ff <= edge_sel_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_IMPLY(a_decide_after_end_edge, state_ff == ST_DECIDE, edge_sel_ff == 1'b0 && $past(state_ff) == ST_PIXEL, "merge decision taken before both edges were converted")
   `ASSERT_NEXT(a_start_then_end, state_ff == ST_PIXEL && !edge_sel_ff, state_ff == ST_DIFF && edge_sel_ff, "end edge conversion did not follow the start edge")

endmodule
